// ----- hw/rtl/msb_pkg.sv -----
// Shared types and constants for the merge sort buffer.
`default_nettype none

package msb_pkg;

  localparam int DATA_W = 32;

  // Controller states
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PRIME,
    ST_MERGE,
    ST_OUT_PRIME,
    ST_OUT
  } state_t;

  // Datapath operations issued by the controller
  typedef enum logic [2:0] {
    OP_IDLE,
    OP_LOAD,
    OP_LOAD_LAST,
    OP_MERGE,
    OP_OUT_INIT,
    OP_OUT_NEXT
  } op_t;

  // Datapath status back to the controller
  typedef struct packed {
    logic need_sort;  // batch holds two or more values after this load
    logic pass_end;   // current merge step writes the last slot of a pass
    logic sort_done;  // doubled run width of the current pass covers the whole batch
    logic out_last;   // output pointer sits on the final value
  } status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/msb_datapath.sv -----
// Datapath: ping-pong value banks, merge pointers and the output register.
`default_nettype none

module msb_datapath #(
  parameter int CAPACITY = 32
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire msb_pkg::op_t                 op,
  input  wire logic signed [msb_pkg::DATA_W-1:0] in_value,
  output msb_pkg::status_t                  status,
  output logic signed [msb_pkg::DATA_W-1:0] sorted_value,
  output logic                              last_out,
  output logic                              overflowed
);

  localparam int CW = $clog2(CAPACITY + 1);  // counts 0..CAPACITY
  localparam int AW = $clog2(CAPACITY);      // bank address
  localparam int SW = CW + 2;                // run-bound sums and width
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  // Two banks: the source of a pass is read, the other one written
  logic signed [msb_pkg::DATA_W-1:0] bank0 [CAPACITY];
  logic signed [msb_pkg::DATA_W-1:0] bank1 [CAPACITY];

  logic [CW-1:0] count_r, count_nxt;
  logic          ovf_r, ovf_nxt;
  logic          src_r, src_nxt;
  logic [SW-1:0] width_r, width_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [CW-1:0] mid_r, mid_nxt;
  logic [CW-1:0] hi_r, hi_nxt;
  logic signed [msb_pkg::DATA_W-1:0] rd_a_r, rd_b_r;

  logic          full;
  logic [CW-1:0] count_inc;
  logic          take_b;
  logic          run_end;
  logic          run_init;
  logic [CW-1:0] run_lo;
  logic [SW-1:0] run_w;
  logic [CW-1:0] run_n;
  logic [SW-1:0] mid_sum, hi_sum;
  logic [CW-1:0] mid_c, hi_c;
  logic          wr0_en, wr1_en;
  logic [AW-1:0] wr_addr;
  logic signed [msb_pkg::DATA_W-1:0] wr_data;
  logic [AW-1:0] rd_addr_a, rd_addr_b;

  assign full      = (count_r == CAP_C);
  assign count_inc = count_r + CW'(1);
  assign run_end   = (k_r + CW'(1) == hi_r);

  // Status to the controller
  assign status.need_sort = full || (count_r != '0);
  assign status.pass_end  = (k_r + CW'(1) == count_r);
  assign status.sort_done = ((width_r << 1) >= SW'(count_r));
  assign status.out_last  = (i_r + CW'(1) == count_r);

  // Merge choice: right run wins when strictly smaller or once the left run is used up
  assign take_b = (j_r < hi_r) && ((i_r >= mid_r) || (rd_b_r < rd_a_r));

  // Bounds of the next run pair, clipped to the batch size
  assign mid_sum = SW'(run_lo) + run_w;
  assign mid_c   = (mid_sum > SW'(run_n)) ? run_n : mid_sum[CW-1:0];
  assign hi_sum  = SW'(mid_c) + run_w;
  assign hi_c    = (hi_sum > SW'(run_n)) ? run_n : hi_sum[CW-1:0];

  // Next-value logic for counters and pointers
  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    src_nxt   = src_r;
    width_nxt = width_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    mid_nxt   = mid_r;
    hi_nxt    = hi_r;
    run_init  = 1'b0;
    run_lo    = '0;
    run_w     = width_r;
    run_n     = count_r;
    wr0_en    = 1'b0;
    wr1_en    = 1'b0;
    wr_addr   = count_r[AW-1:0];
    wr_data   = in_value;
    unique case (op)
      msb_pkg::OP_LOAD, msb_pkg::OP_LOAD_LAST: begin
        if (full) begin
          ovf_nxt = 1'b1;
        end else begin
          count_nxt = count_inc;
          wr0_en    = 1'b1;
        end
        if (op == msb_pkg::OP_LOAD_LAST) begin
          run_init  = 1'b1;
          run_w     = SW'(1);
          run_n     = count_nxt;
          width_nxt = SW'(1);
          k_nxt     = '0;
        end
      end
      msb_pkg::OP_MERGE: begin
        wr_addr = k_r[AW-1:0];
        wr_data = take_b ? rd_b_r : rd_a_r;
        wr0_en  = src_r;
        wr1_en  = ~src_r;
        k_nxt   = k_r + CW'(1);
        if (take_b) begin
          j_nxt = j_r + CW'(1);
        end else begin
          i_nxt = i_r + CW'(1);
        end
        if (status.pass_end) begin
          // next pass reads what this pass wrote, at twice the run width
          src_nxt   = ~src_r;
          width_nxt = width_r << 1;
          run_init  = 1'b1;
          run_w     = width_r << 1;
          k_nxt     = '0;
        end else if (run_end) begin
          run_init = 1'b1;
          run_lo   = hi_r;
        end
      end
      msb_pkg::OP_OUT_INIT: begin
        i_nxt = '0;
      end
      msb_pkg::OP_OUT_NEXT: begin
        if (status.out_last) begin
          count_nxt = '0;
          ovf_nxt   = 1'b0;
          src_nxt   = 1'b0;
        end else begin
          i_nxt = i_r + CW'(1);
        end
      end
      default: begin
      end
    endcase
    if (run_init) begin
      i_nxt   = run_lo;
      j_nxt   = mid_c;
      mid_nxt = mid_c;
      hi_nxt  = hi_c;
    end
  end

  assign rd_addr_a = i_nxt[AW-1:0];
  assign rd_addr_b = j_nxt[AW-1:0];

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
      src_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      src_r   <= src_nxt;
    end
  end

  // Pointer registers
  always_ff @(posedge clk) begin
    width_r <= width_nxt;
    i_r     <= i_nxt;
    j_r     <= j_nxt;
    k_r     <= k_nxt;
    mid_r   <= mid_nxt;
    hi_r    <= hi_nxt;
  end

  // Bank writes
  always_ff @(posedge clk) begin
    if (wr0_en) begin
      bank0[wr_addr] <= wr_data;
    end
    if (wr1_en) begin
      bank1[wr_addr] <= wr_data;
    end
  end

  // Registered reads at the heads of both runs, from the source bank
  always_ff @(posedge clk) begin
    rd_a_r <= src_r ? bank1[rd_addr_a] : bank0[rd_addr_a];
    rd_b_r <= src_r ? bank1[rd_addr_b] : bank0[rd_addr_b];
  end

  assign sorted_value = rd_a_r;
  assign last_out     = status.out_last;
  assign overflowed   = ovf_r;

endmodule

`default_nettype wire

// ----- hw/rtl/msb_ctrl.sv -----
// Controller: load, merge passes and output sequencing.
`default_nettype none

module msb_ctrl (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  input  wire              in_last_in,
  input  wire              out_stall,
  input  wire msb_pkg::status_t status,
  output msb_pkg::op_t     op,
  output logic             in_stall,
  output logic             out_valid
);

  msb_pkg::state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= msb_pkg::ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      msb_pkg::ST_LOAD: begin
        if (in_valid && in_last_in) begin
          state_nxt = status.need_sort ? msb_pkg::ST_PRIME : msb_pkg::ST_OUT_PRIME;
        end
      end
      msb_pkg::ST_PRIME: begin
        state_nxt = msb_pkg::ST_MERGE;
      end
      msb_pkg::ST_MERGE: begin
        if (status.pass_end) begin
          state_nxt = status.sort_done ? msb_pkg::ST_OUT_PRIME : msb_pkg::ST_PRIME;
        end
      end
      msb_pkg::ST_OUT_PRIME: begin
        state_nxt = msb_pkg::ST_OUT;
      end
      msb_pkg::ST_OUT: begin
        if (!out_stall && status.out_last) begin
          state_nxt = msb_pkg::ST_LOAD;
        end
      end
      default: begin
        state_nxt = msb_pkg::ST_LOAD;
      end
    endcase
  end

  // Outputs
  always_comb begin
    op        = msb_pkg::OP_IDLE;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      msb_pkg::ST_LOAD: begin
        in_stall = 1'b0;
        if (in_valid) begin
          op = in_last_in ? msb_pkg::OP_LOAD_LAST : msb_pkg::OP_LOAD;
        end
      end
      msb_pkg::ST_PRIME: begin
        op = msb_pkg::OP_IDLE;
      end
      msb_pkg::ST_MERGE: begin
        op = msb_pkg::OP_MERGE;
      end
      msb_pkg::ST_OUT_PRIME: begin
        op = msb_pkg::OP_OUT_INIT;
      end
      msb_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          op = msb_pkg::OP_OUT_NEXT;
        end
      end
      default: begin
        op = msb_pkg::OP_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/merge_sort_buffer_top.sv -----
// Loads up to CAPACITY values, merge-sorts them, streams them out in order.
// Load: one transfer per cycle. After the last item, a batch of n values takes
// ceil(log2 n) merge passes, each a prime step then one bank write per cycle, then
// a fetch step, then one result per cycle while out_stall is low. Input stalls
// from the last item to the final result. Reset (rst_n low, synchronous) empties
// the batch; bank contents are kept.
`default_nettype none

module merge_sort_buffer_top #(
  parameter int CAPACITY = 32
) (
  input  wire                                    clk,
  input  wire                                    rst_n,
  input  wire                                    in_valid,
  output logic                                   in_stall,
  input  wire logic signed [msb_pkg::DATA_W-1:0] in_value,
  input  wire                                    in_last_in,
  output logic                                   out_valid,
  input  wire                                    out_stall,
  output logic signed [msb_pkg::DATA_W-1:0]      out_sorted_value,
  output logic                                   out_last_out,
  output logic                                   out_overflowed
);

  msb_pkg::op_t     op;
  msb_pkg::status_t status;

  // Sequencer
  msb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_last_in (in_last_in),
    .out_stall  (out_stall),
    .status     (status),
    .op         (op),
    .in_stall   (in_stall),
    .out_valid  (out_valid)
  );

  // Banks and pointers
  msb_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .op           (op),
    .in_value     (in_value),
    .status       (status),
    .sorted_value (out_sorted_value),
    .last_out     (out_last_out),
    .overflowed   (out_overflowed)
  );

`ifndef SYNTHESIS
  // Loading and emitting never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !out_valid)
    else $error("input ready while results pending");

  // Final result transfer reopens the input
  a_reopen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_last_out |=> !in_stall && !out_valid)
    else $error("input not reopened after final result");

  // A non-final transfer is followed by more results with the same overflow flag
  a_ovf_steady: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_out |=> out_valid && $stable(out_overflowed))
    else $error("overflow flag changed within a batch");
`endif

endmodule

`default_nettype wire

// ----- bench/merge_sort_buffer_top_tb.sv -----
// Testbench for merge_sort_buffer_top: batches of values in, sorted stream out, checked in order.
`timescale 1ns / 1ps

module merge_sort_buffer_top_tb;

  localparam int CAPACITY   = 32;
  localparam int LONG_HOLD  = 400;
  localparam int RAND_ITEMS = 280;
  localparam int DRAIN      = 64;

  typedef logic signed [msb_pkg::DATA_W-1:0] word_t;

  localparam word_t VAL_MAX = 32'sh7FFF_FFFF;
  localparam word_t VAL_MIN = 32'sh8000_0000;

  // one sorted output beat as the block should present it
  typedef struct packed {
    word_t value;
    logic  last;
    logic  ovf;
  } sorted_entry_t;

  // one directed stimulus row; typed rows carry their known single result
  typedef struct packed {
    word_t value;
    logic  last;
    logic  typed;
    word_t typed_value;
  } stim_row_t;

  logic  clk;
  logic  rst_n;
  logic  in_valid;
  logic  in_stall;
  word_t in_value;
  logic  in_last_in;
  logic  out_valid;
  logic  out_stall;
  word_t out_sorted_value;
  logic  out_last_out;
  logic  out_overflowed;

  // predictor state: values of the open batch and its overflow flag
  word_t         batch_vals [$];
  bit            batch_overflow;
  sorted_entry_t pending_sorted [$];

  int errors;
  bit rx_hold_req;
  bit no_idle;
  bit tx_calm;

  stim_row_t directed_rows [22];

  merge_sort_buffer_top #(
    .CAPACITY(CAPACITY)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_value         (in_value),
    .in_last_in       (in_last_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sorted_value (out_sorted_value),
    .out_last_out     (out_last_out),
    .out_overflowed   (out_overflowed)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit, far above the slowest legal run
  initial begin
    #6_000_000;
    $display("Mismatches found");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    errors++;
  endtask

  // ascending insertion sort of the open batch; tie order is irrelevant
  task automatic sort_batch();
    word_t key;
    int    j;
    for (int i = 1; i < batch_vals.size(); i++) begin
      key = batch_vals[i];
      j = i - 1;
      while (j >= 0 && batch_vals[j] > key) begin
        batch_vals[j+1] = batch_vals[j];
        j--;
      end
      batch_vals[j+1] = key;
    end
  endtask

  // predictor: absorb one accepted value, emit the sorted batch on last
  task automatic take_value(input word_t v, input logic l, input bit typed,
                            input word_t typed_value);
    int n;
    if (batch_vals.size() < CAPACITY) begin
      batch_vals.push_back(v);
    end else begin
      batch_overflow = 1'b1;
    end
    if (l) begin
      sort_batch();
      n = batch_vals.size();
      if (typed) begin
        pending_sorted.push_back(sorted_entry_t'{typed_value, 1'b1, 1'b0});
      end else begin
        for (int k = 0; k < n; k++)
          pending_sorted.push_back(sorted_entry_t'{batch_vals[k], k == n - 1,
                                                   batch_overflow});
      end
      batch_vals.delete();
      batch_overflow = 1'b0;
    end
  endtask

  // offer one item, wait for the transfer, then maybe idle a burst
  task automatic send_value(input word_t v, input logic l, input bit typed,
                            input word_t typed_value);
    int gap;
    in_valid   <= 1'b1;
    in_value   <= v;
    in_last_in <= l;
    do @(posedge clk); while (in_stall);
    take_value(v, l, typed, typed_value);
    if (!no_idle && !tx_calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic word_t pick_value();
    case ($urandom_range(0, 7))
      0:       pick_value = VAL_MAX;
      1:       pick_value = VAL_MIN;
      2, 3:    pick_value = int'($urandom_range(0, 6)) - 3;  // dense ties
      default: pick_value = $urandom;
    endcase
  endfunction

  // mostly short batches, some long, a few full or overflowing
  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12)       pick_len = $urandom_range(1, 8);
    else if (r < 17)  pick_len = $urandom_range(9, CAPACITY - 1);
    else if (r == 17) pick_len = CAPACITY;
    else if (r == 18) pick_len = $urandom_range(CAPACITY + 1, CAPACITY + 6);
    else              pick_len = 1;
  endfunction

  task automatic send_batch(input int len);
    tx_calm = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < len; i++)
      send_value(pick_value(), i == len - 1, 1'b0, '0);
  endtask

  // wait until every pending result has been seen or the limit runs out
  task automatic drain_results(input int limit);
    int waited;
    waited = 0;
    while (pending_sorted.size() != 0 && waited < limit) begin
      @(posedge clk);
      waited++;
    end
  endtask

  // result side: random stall bursts, one long hold on request, calm stretches
  initial begin : receiver
    int hold;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 9) == 0) begin
        hold = $urandom_range(1, 12);
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 15) == 0) begin
        hold = $urandom_range(20, 60);
        repeat (hold) @(posedge clk);
      end
    end
  end

  // compare every result transfer against the oldest expectation
  always @(posedge clk) begin
    sorted_entry_t exp_entry;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_sorted.size() == 0) begin
        report_mismatch($sformatf("unexpected result value=%0d", out_sorted_value));
      end else begin
        exp_entry = pending_sorted.pop_front();
        if (out_sorted_value !== exp_entry.value)
          report_mismatch($sformatf("sorted_value got %0d expected %0d",
                                    out_sorted_value, exp_entry.value));
        if (out_last_out !== exp_entry.last)
          report_mismatch($sformatf("last_out got %b expected %b (value %0d)",
                                    out_last_out, exp_entry.last, exp_entry.value));
        if (out_overflowed !== exp_entry.ovf)
          report_mismatch($sformatf("overflowed got %b expected %b (value %0d)",
                                    out_overflowed, exp_entry.ovf, exp_entry.value));
      end
    end
  end

  initial begin : stimulus
    int sent;
    int len;
    bit paused;

    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_value    = '0;
    in_last_in  = 1'b0;
    errors      = 0;
    rx_hold_req = 1'b0;
    no_idle     = 1'b0;
    tx_calm     = 1'b0;
    batch_overflow = 1'b0;
    paused      = 1'b0;

    // single-value batches have a known result; the rest go to the predictor
    directed_rows = '{
      '{VAL_MAX,        1'b1, 1'b1, VAL_MAX},
      '{VAL_MIN,        1'b1, 1'b1, VAL_MIN},
      '{32'sd0,         1'b1, 1'b1, 32'sd0},
      '{-32'sd1,        1'b1, 1'b1, -32'sd1},
      '{VAL_MAX,        1'b0, 1'b0, 32'sd0},
      '{VAL_MIN,        1'b0, 1'b0, 32'sd0},
      '{32'sd0,         1'b1, 1'b0, 32'sd0},
      '{32'sd5,         1'b0, 1'b0, 32'sd0},
      '{-32'sd5,        1'b0, 1'b0, 32'sd0},
      '{32'sd5,         1'b0, 1'b0, 32'sd0},
      '{-32'sd5,        1'b1, 1'b0, 32'sd0},
      '{32'sd4,         1'b0, 1'b0, 32'sd0},
      '{32'sd3,         1'b0, 1'b0, 32'sd0},
      '{32'sd2,         1'b0, 1'b0, 32'sd0},
      '{32'sd1,         1'b0, 1'b0, 32'sd0},
      '{32'sd0,         1'b1, 1'b0, 32'sd0},
      '{-32'sd3,        1'b0, 1'b0, 32'sd0},
      '{-32'sd2,        1'b0, 1'b0, 32'sd0},
      '{-32'sd1,        1'b1, 1'b0, 32'sd0},
      '{32'sh5555_5555, 1'b0, 1'b0, 32'sd0},
      '{32'shAAAA_AAAA, 1'b0, 1'b0, 32'sd0},
      '{32'sd1,         1'b1, 1'b0, 32'sd0}
    };

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    foreach (directed_rows[i])
      send_value(directed_rows[i].value, directed_rows[i].last,
                 directed_rows[i].typed, directed_rows[i].typed_value);

    // boundary sizes: exactly full, last item dropped, several dropped
    send_batch(CAPACITY);
    send_batch(CAPACITY + 1);
    send_batch(CAPACITY + 3);

    // receiver holds off while the sender keeps offering
    rx_hold_req = 1'b1;
    send_batch(CAPACITY + 4);
    send_batch(6);

    // random batches; one full drain midway, no idling near the end
    sent = 0;
    while (sent < RAND_ITEMS) begin
      len = pick_len();
      if (sent >= RAND_ITEMS - 70)
        no_idle = 1'b1;
      send_batch(len);
      sent += len;
      if (!paused && sent >= RAND_ITEMS / 2) begin
        paused = 1'b1;
        in_valid <= 1'b0;
        drain_results(200000);
        @(posedge clk);
      end
    end
    in_valid <= 1'b0;

    // wait out the tail, then a little more for anything extra
    drain_results(200000);
    repeat (DRAIN) @(posedge clk);
    if (pending_sorted.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived",
                                pending_sorted.size()));

    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/msb_pkg.sv
hw/rtl/msb_datapath.sv
hw/rtl/msb_ctrl.sv
hw/rtl/merge_sort_buffer_top.sv
bench/merge_sort_buffer_top_tb.sv
